// ===== rtl/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, codes and helpers of the accumulator processor step block.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int WORD_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int REG_COUNT = 32;
  localparam int REG_AW  = $clog2(REG_COUNT);

  // Flag vector layout.
  localparam int FLAG_C = 0;
  localparam int FLAG_N = 1;
  localparam int FLAG_Z = 2;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [2:0] {
    OP_NOR  = 3'd0,
    OP_ADD  = 3'd1,
    OP_LD   = 3'd2,
    OP_MOVE = 3'd3,
    OP_SD   = 3'd4,
    OP_SETI = 3'd5,
    OP_JL   = 3'd6,
    OP_SRL  = 3'd7
  } op_t;

  // A load command reports the opcode field as zero.
  localparam logic [2:0] LOAD_REPORT_OP = 3'd0;

  // Jump conditions held in the top three bits of a JL operand byte.
  localparam logic [2:0] COND_NEVER  = 3'd0;
  localparam logic [2:0] COND_C      = 3'd1;
  localparam logic [2:0] COND_N      = 3'd2;
  localparam logic [2:0] COND_NC     = 3'd3;
  localparam logic [2:0] COND_Z      = 3'd4;
  localparam logic [2:0] COND_ZC     = 3'd5;
  localparam logic [2:0] COND_ZN     = 3'd6;
  localparam logic [2:0] COND_ALWAYS = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DEC  = 2'd1,
    S_EXEC = 2'd2,
    S_LATE = 2'd3
  } state_t;

  // Program memory access for one cycle: one write and one read port.
  typedef struct packed {
    logic              we;
    logic [WORD_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [WORD_W-1:0] raddr;
  } mem_req_t;

  // Register file access for one cycle.
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [REG_AW-1:0] raddr;
  } rf_req_t;

  // Register contents after reset.
  function automatic logic [WORD_W-1:0] reg_init(input logic [REG_AW-1:0] idx);
    logic [WORD_W-1:0] v;
    v = '0;
    if (idx == REG_AW'(30)) v = 16'h0001;
    if (idx == REG_AW'(31)) v = 16'hffff;
    return v;
  endfunction

  function automatic logic cond_holds(input logic [2:0] cond, input logic [2:0] f);
    logic ok;
    case (cond)
      COND_NEVER:  ok = 1'b0;
      COND_C:      ok = f[FLAG_C];
      COND_N:      ok = f[FLAG_N];
      COND_NC:     ok = f[FLAG_N] | f[FLAG_C];
      COND_Z:      ok = f[FLAG_Z];
      COND_ZC:     ok = f[FLAG_Z] | f[FLAG_C];
      COND_ZN:     ok = f[FLAG_Z] | f[FLAG_N];
      default:     ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

// ===== rtl/acs_prog_mem.sv =====
// ----------------------------------------------------------------------------
// acs_prog_mem
// Byte-wide program and data memory with a registered read port and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module acs_prog_mem #(
  parameter int MEM_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  acs_pkg::mem_req_t  req,
  output logic [7:0]         rdata,
  output logic               busy
);

  localparam int  AW      = $clog2(MEM_BYTES);
  localparam int  SH      = 16 - AW;
  localparam bit  IS_POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);

  logic [7:0]    mem [MEM_BYTES];
  logic [AW-1:0] clr_addr;

  // Reduce a 16-bit address into the memory. For a depth that is not a power
  // of two, a short restoring reduction removes shifted copies of the depth.
  function automatic logic [AW-1:0] reduce(input logic [15:0] a);
    logic [16:0] r;
    logic [16:0] m;
    r = {1'b0, a};
    m = '0;
    if (!IS_POW2) begin
      for (int k = SH; k >= 0; k--) begin
        m = 17'(MEM_BYTES) << k;
        if (r >= m) r = r - m;
      end
    end
    return r[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MEM_BYTES - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (req.we) begin
      mem[reduce(req.waddr)] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[reduce(req.raddr)];
  end

endmodule

// ===== rtl/acs_reg_file.sv =====
// ----------------------------------------------------------------------------
// acs_reg_file
// Thirty-two 16-bit registers with a registered read port, loaded with their
// start values by a sweep after reset.
// ----------------------------------------------------------------------------
module acs_reg_file (
  input  logic                             clk,
  input  logic                             rst,
  input  acs_pkg::rf_req_t                 req,
  output logic [acs_pkg::WORD_W-1:0]       rdata,
  output logic                             busy
);

  logic [acs_pkg::WORD_W-1:0] regs [acs_pkg::REG_COUNT];
  logic [acs_pkg::REG_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + acs_pkg::REG_AW'(1);
      if (clr_addr == acs_pkg::REG_AW'(acs_pkg::REG_COUNT - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      regs[clr_addr] <= acs_pkg::reg_init(clr_addr);
    end else if (req.we) begin
      regs[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= regs[req.raddr];
  end

endmodule

// ===== rtl/accumulator_cpu_step.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_step
// 16-bit accumulator processor core that loads program bytes and executes
// one instruction per step command.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Payload
//   -------   ------------------   ---------------------------------------------
//   input     in_valid / in_stall  command, load_address, load_byte
//   output    out_valid / out_stall program_counter, accumulator, status_flags,
//                                  executed_opcode, branch_taken
//
// A load command completes in the idle state of the sequencer. NOR, ADD, MOVE, SD,
// JL and SRL pass through fetch, decode with operand reads and execute, while LD
// and SETI add a late state because they need a second read of the program memory.
// The program memory has a single read port. All wait for a free output register.
// After reset the block clears the program memory, one byte a cycle, so
// in_stall stays high until that sweep is done; the register file loads its start
// values during the same sweep.
// A one-entry input buffer takes the next transfer while an instruction runs,
// and the output register holds a finished result while out_stall is high.
// ----------------------------------------------------------------------------
module accumulator_cpu_step #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] load_address,
  input  logic [7:0]  load_byte,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] program_counter,
  output logic [15:0] accumulator,
  output logic [2:0]  status_flags,
  output logic [2:0]  executed_opcode,
  output logic        branch_taken
);

  // Sequencer state.
  acs_pkg::state_t state, state_next;

  // Input buffer: holds one transfer until the sequencer takes it.
  logic        ibuf_valid;
  logic        ibuf_cmd;
  logic [15:0] ibuf_addr;
  logic [7:0]  ibuf_byte;

  // Architectural state outside the memories.
  logic [15:0] pc;
  logic [15:0] acc;
  logic [2:0]  flags;

  // Instruction byte and the low byte of a SETI immediate.
  logic [7:0]  ib_q;
  logic [7:0]  lo_q;

  // Memory ports.
  acs_pkg::mem_req_t mreq;
  acs_pkg::rf_req_t  rreq;
  logic [7:0]        mem_rdata;
  logic [15:0]       rf_rdata;
  logic              mem_busy;
  logic              rf_busy;
  logic              busy;

  // Sequencer outputs.
  logic        take;
  logic        finish;
  logic        lo_load;
  logic [15:0] res_pc;
  logic [15:0] res_acc;
  logic [2:0]  res_flags;
  logic [2:0]  res_op;
  logic        res_taken;

  logic        out_free;

  // Decode helpers.
  acs_pkg::op_t                  opc;
  logic [acs_pkg::REG_AW-1:0]    sel_x;
  logic [acs_pkg::REG_AW-1:0]    sel_link;
  logic [2:0]                    jl_cond;
  logic [16:0]                   add_sum;
  logic [15:0]                   nor_val;
  logic [15:0]                   srl_val;

  acs_prog_mem #(
    .MEM_BYTES(MEM_BYTES)
  ) u_prog_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  acs_reg_file u_reg_file (
    .clk   (clk),
    .rst   (rst),
    .req   (rreq),
    .rdata (rf_rdata),
    .busy  (rf_busy)
  );

  assign busy     = mem_busy | rf_busy;
  assign in_stall = busy | ibuf_valid;
  assign out_free = !out_valid || !out_stall;

  // Input buffer. A transfer only lands when the buffer is empty, and the
  // sequencer only takes from a full buffer, so the two never coincide.
  always_ff @(posedge clk) begin
    if (rst) begin
      ibuf_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ibuf_valid <= 1'b1;
    end else if (take) begin
      ibuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ibuf_cmd  <= command;
      ibuf_addr <= load_address;
      ibuf_byte <= load_byte;
    end
  end

  assign opc      = acs_pkg::op_t'(ib_q[7:5]);
  assign sel_x    = ib_q[acs_pkg::REG_AW-1:0];
  assign sel_link = mem_rdata[acs_pkg::REG_AW-1:0];
  assign jl_cond  = mem_rdata[7:5];
  assign add_sum  = {1'b0, acc} + {1'b0, rf_rdata};
  assign nor_val  = ~(acc | rf_rdata);
  assign srl_val  = {1'b0, acc[15:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer. Read addresses stay put while a state waits for the output
  // register, so the registered read data stays valid across the wait.
  always_comb begin
    state_next  = state;
    take        = 1'b0;
    finish      = 1'b0;
    lo_load     = 1'b0;
    mreq        = '0;
    mreq.raddr  = pc;
    rreq        = '0;
    rreq.raddr  = sel_x;
    res_pc      = pc;
    res_acc     = acc;
    res_flags   = flags;
    res_op      = acs_pkg::LOAD_REPORT_OP;
    res_taken   = 1'b0;

    case (state)
      acs_pkg::S_IDLE: begin
        mreq.raddr = pc;
        if (ibuf_valid) begin
          if (ibuf_cmd == acs_pkg::CMD_LOAD) begin
            if (out_free) begin
              take       = 1'b1;
              finish     = 1'b1;
              mreq.we    = 1'b1;
              mreq.waddr = ibuf_addr;
              mreq.wdata = ibuf_byte;
            end
          end else begin
            take       = 1'b1;
            state_next = acs_pkg::S_DEC;
          end
        end
      end

      acs_pkg::S_DEC: begin
        // Instruction byte arrives; read rX and the byte after it.
        mreq.raddr = pc + 16'd1;
        rreq.raddr = mem_rdata[acs_pkg::REG_AW-1:0];
        state_next = acs_pkg::S_EXEC;
      end

      acs_pkg::S_EXEC: begin
        mreq.raddr = pc + 16'd1;
        res_op     = opc;
        case (opc)
          acs_pkg::OP_LD: begin
            mreq.raddr = rf_rdata;
            state_next = acs_pkg::S_LATE;
          end
          acs_pkg::OP_SETI: begin
            mreq.raddr = pc + 16'd2;
            lo_load    = 1'b1;
            state_next = acs_pkg::S_LATE;
          end
          default: begin
            if (out_free) begin
              finish     = 1'b1;
              state_next = acs_pkg::S_IDLE;
              res_pc     = pc + 16'd1;
              case (opc)
                acs_pkg::OP_NOR: begin
                  res_acc                    = nor_val;
                  res_flags[acs_pkg::FLAG_Z] = (nor_val == 16'd0);
                  res_flags[acs_pkg::FLAG_N] = nor_val[15];
                end
                acs_pkg::OP_ADD: begin
                  res_acc                    = add_sum[15:0];
                  res_flags[acs_pkg::FLAG_C] = add_sum[16];
                  res_flags[acs_pkg::FLAG_Z] = (add_sum[15:0] == 16'd0);
                  res_flags[acs_pkg::FLAG_N] = add_sum[15];
                end
                acs_pkg::OP_MOVE: begin
                  rreq.we    = 1'b1;
                  rreq.waddr = sel_x;
                  rreq.wdata = acc;
                end
                acs_pkg::OP_SD: begin
                  mreq.we    = 1'b1;
                  mreq.waddr = rf_rdata;
                  mreq.wdata = acc[7:0];
                end
                acs_pkg::OP_JL: begin
                  // The link is written first, so a jump through the same
                  // register lands on the JL itself.
                  rreq.we    = 1'b1;
                  rreq.waddr = sel_link;
                  rreq.wdata = pc;
                  if (acs_pkg::cond_holds(jl_cond, flags)) begin
                    res_taken = 1'b1;
                    res_pc    = (sel_link == sel_x) ? pc : rf_rdata;
                  end else begin
                    res_pc    = pc + 16'd2;
                  end
                end
                acs_pkg::OP_SRL: begin
                  res_acc                    = srl_val;
                  res_flags[acs_pkg::FLAG_Z] = (srl_val == 16'd0);
                end
                default: begin
                  res_acc = acc;
                end
              endcase
            end
          end
        endcase
      end

      acs_pkg::S_LATE: begin
        res_op = opc;
        if (opc == acs_pkg::OP_LD) begin
          mreq.raddr = rf_rdata;
        end else begin
          mreq.raddr = pc + 16'd2;
        end
        if (out_free) begin
          finish     = 1'b1;
          state_next = acs_pkg::S_IDLE;
          if (opc == acs_pkg::OP_LD) begin
            res_acc = {8'd0, mem_rdata};
            res_pc  = pc + 16'd1;
          end else begin
            res_acc = {mem_rdata, lo_q};
            res_pc  = pc + 16'd3;
          end
        end
      end

      default: begin
        state_next = acs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == acs_pkg::S_DEC) ib_q <= mem_rdata;
    if (lo_load) lo_q <= mem_rdata;
  end

  // Architectural registers commit when a result enters the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc    <= '0;
      acc   <= '0;
      flags <= '0;
    end else if (finish) begin
      pc    <= res_pc;
      acc   <= res_acc;
      flags <= res_flags;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      program_counter <= res_pc;
      accumulator     <= res_acc;
      status_flags    <= res_flags;
      executed_opcode <= res_op;
      branch_taken    <= res_taken;
    end
  end

`ifndef SYNTHESIS
  // A result never overwrites one that is still waiting to be taken.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    finish |-> out_free)
    else $error("result finished while output register was held");

  // The sequencer never writes the memories during the clearing sweep.
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (mreq.we || rreq.we) |-> !busy)
    else $error("memory write during clearing sweep");

  // Decode always follows the fetch issued from idle.
  a_dec_after_idle: assert property (@(posedge clk) disable iff (rst)
    (state == acs_pkg::S_DEC) |-> ($past(state) == acs_pkg::S_IDLE))
    else $error("decode state entered out of order");

  // The second memory read only serves LD and SETI.
  a_late_ops: assert property (@(posedge clk) disable iff (rst)
    (state == acs_pkg::S_LATE) |-> (opc == acs_pkg::OP_LD || opc == acs_pkg::OP_SETI))
    else $error("late state with wrong opcode");

  // Nothing is taken from the input buffer while the memories are cleared.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !take)
    else $error("item taken during clearing sweep");
`endif

endmodule

// ===== sim/tb_accumulator_cpu_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accumulator_cpu_step
// Self-checking testbench for the accumulator processor step block. It keeps
// its own copy of memory, registers, accumulator, counter and flags, predicts
// the result of every accepted transfer and compares each output transfer
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_accumulator_cpu_step;

  localparam int MEM_BYTES   = 65536;
  // The block clears memory after reset, so the limit covers that sweep
  // plus a slow run of every item with full idling on both sides.
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  // Expected content of one output transfer.
  typedef struct packed {
    logic [15:0]  pc;
    logic [15:0]  acc;
    logic [2:0]   flags;
    acs_pkg::op_t op;
    logic         taken;
  } cpu_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = acs_pkg::CMD_LOAD;
  logic [15:0] load_address = '0;
  logic [7:0]  load_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] program_counter;
  logic [15:0] accumulator;
  logic [2:0]  status_flags;
  logic [2:0]  executed_opcode;
  logic        branch_taken;

  // Predicted architectural state of the core.
  logic [7:0]  mem_image [0:MEM_BYTES-1];
  logic [15:0] reg_image [0:acs_pkg::REG_COUNT-1];
  logic [15:0] model_acc;
  logic [15:0] model_pc;
  logic [2:0]  model_flags;

  cpu_result_t pending_results[$];
  int          error_count = 0;
  int          items_sent = 0;
  int          cycle_count = 0;

  // Test controls for the idling of both sides and the long receiver hold.
  logic        idle_enable = 1'b0;
  logic        hold_request = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  int          stall_left = 0;

  accumulator_cpu_step #(
    .MEM_BYTES(MEM_BYTES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .load_address(load_address),
    .load_byte(load_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .program_counter(program_counter),
    .accumulator(accumulator),
    .status_flags(status_flags),
    .executed_opcode(executed_opcode),
    .branch_taken(branch_taken)
  );

  always #5 clk = ~clk;

  // Global watchdog. A hang anywhere, including a block that never leaves
  // its clearing sweep, ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Puts the model into its post-reset state: memory cleared, all registers
  // zero except the two preset ones at the top of the file.
  task automatic model_reset();
    for (int i = 0; i < MEM_BYTES; i++) mem_image[i] = 8'h00;
    for (int i = 0; i < acs_pkg::REG_COUNT; i++) reg_image[i] = 16'h0000;
    reg_image[29] = 16'h0000;
    reg_image[30] = 16'h0001;
    reg_image[31] = 16'hffff;
    model_acc   = '0;
    model_pc    = '0;
    model_flags = '0;
  endtask

  function automatic logic jump_condition(input logic [2:0] cond, input logic [2:0] f);
    case (cond)
      acs_pkg::COND_NEVER:  return 1'b0;
      acs_pkg::COND_C:      return f[acs_pkg::FLAG_C];
      acs_pkg::COND_N:      return f[acs_pkg::FLAG_N];
      acs_pkg::COND_NC:     return f[acs_pkg::FLAG_N] | f[acs_pkg::FLAG_C];
      acs_pkg::COND_Z:      return f[acs_pkg::FLAG_Z];
      acs_pkg::COND_ZC:     return f[acs_pkg::FLAG_Z] | f[acs_pkg::FLAG_C];
      acs_pkg::COND_ZN:     return f[acs_pkg::FLAG_Z] | f[acs_pkg::FLAG_N];
      default:              return 1'b1;
    endcase
  endfunction

  // Applies one accepted transfer to the model and queues the result it
  // must produce. Addresses wrap at 16 bits before the memory size is applied.
  task automatic model_execute(input logic cmd, input logic [15:0] addr,
                               input logic [7:0] data);
    cpu_result_t  res;
    logic [7:0]   ib;
    logic [7:0]   b2;
    logic [4:0]   rx;
    logic [15:0]  a1;
    logic [15:0]  a2;
    logic [16:0]  sum;
    logic [15:0]  pc_next;
    acs_pkg::op_t op;
    logic         taken;
    op    = acs_pkg::op_t'(acs_pkg::LOAD_REPORT_OP);
    taken = 1'b0;
    if (cmd == acs_pkg::CMD_LOAD) begin
      mem_image[addr % MEM_BYTES] = data;
    end else begin
      ib      = mem_image[model_pc % MEM_BYTES];
      rx      = ib[4:0];
      op      = acs_pkg::op_t'(ib[7:5]);
      a1      = model_pc + 16'd1;
      a2      = model_pc + 16'd2;
      pc_next = a1;
      case (op)
        acs_pkg::OP_NOR: begin
          model_acc = ~(model_acc | reg_image[rx]);
          model_flags[acs_pkg::FLAG_Z] = (model_acc == 16'h0000);
          model_flags[acs_pkg::FLAG_N] = model_acc[15];
        end
        acs_pkg::OP_ADD: begin
          sum = {1'b0, model_acc} + {1'b0, reg_image[rx]};
          model_acc = sum[15:0];
          model_flags[acs_pkg::FLAG_C] = sum[16];
          model_flags[acs_pkg::FLAG_Z] = (model_acc == 16'h0000);
          model_flags[acs_pkg::FLAG_N] = model_acc[15];
        end
        acs_pkg::OP_LD:   model_acc = {8'h00, mem_image[reg_image[rx] % MEM_BYTES]};
        acs_pkg::OP_MOVE: reg_image[rx] = model_acc;
        acs_pkg::OP_SD:   mem_image[reg_image[rx] % MEM_BYTES] = model_acc[7:0];
        acs_pkg::OP_SETI: begin
          model_acc = {mem_image[a2 % MEM_BYTES], mem_image[a1 % MEM_BYTES]};
          pc_next   = model_pc + 16'd3;
        end
        acs_pkg::OP_JL: begin
          // The link is written first, so a jump through the same register
          // lands on the jump-and-link itself.
          b2 = mem_image[a1 % MEM_BYTES];
          reg_image[b2[4:0]] = model_pc;
          if (jump_condition(b2[7:5], model_flags)) begin
            pc_next = reg_image[rx];
            taken   = 1'b1;
          end else begin
            pc_next = a2;
          end
        end
        default: begin
          model_acc = model_acc >> 1;
          model_flags[acs_pkg::FLAG_Z] = (model_acc == 16'h0000);
        end
      endcase
      model_pc = pc_next;
    end
    res.pc    = model_pc;
    res.acc   = model_acc;
    res.flags = model_flags;
    res.op    = op;
    res.taken = taken;
    pending_results.push_back(res);
  endtask

  // Offers one input transfer and returns at the edge where it is taken.
  // Valid stays high afterwards so that back-to-back transfers need no
  // second assignment in the same step; release_input lowers it.
  task automatic send_item(input logic cmd, input logic [15:0] addr,
                           input logic [7:0] data);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    load_address <= addr;
    load_byte    <= data;
    do @(posedge clk); while (in_stall);
    items_sent++;
    model_execute(cmd, addr, data);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes an instruction and the operand bytes it reads at the current
  // program counter, then steps the core once. The step carries random
  // address and data bits, which the block must ignore.
  task automatic exec_instr(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2);
    logic [15:0] at;
    at = model_pc;
    send_item(acs_pkg::CMD_LOAD, at, b0);
    if (b0[7:5] == acs_pkg::OP_SETI || b0[7:5] == acs_pkg::OP_JL)
      send_item(acs_pkg::CMD_LOAD, at + 16'd1, b1);
    if (b0[7:5] == acs_pkg::OP_SETI) send_item(acs_pkg::CMD_LOAD, at + 16'd2, b2);
    send_item(acs_pkg::CMD_STEP, 16'($urandom), 8'($urandom));
  endtask

  // One random well-formed instruction. Now and then the jump-and-link uses
  // the same register for link and target.
  task automatic random_instr();
    logic [7:0] b0;
    logic [7:0] b1;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    if ($urandom_range(0, 7) == 0) b1[4:0] = b0[4:0];
    exec_instr(b0, b1, 8'($urandom));
  endtask

  // Mostly well-formed instructions; the rest is noise: stray memory writes
  // anywhere and steps that run whatever sits at the program counter.
  task automatic random_mix(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       send_item(acs_pkg::CMD_LOAD, 16'($urandom), 8'($urandom));
        1:       send_item(acs_pkg::CMD_STEP, 16'($urandom), 8'($urandom));
        default: random_instr();
      endcase
    end
  endtask

  // Field compare used by the output checker.
  task check_field(input string name, input logic [15:0] exp, input logic [15:0] act);
    if (exp !== act) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
    end
  endtask

  // Output checker: every output transfer is matched against the oldest
  // prediction. A transfer with nothing predicted is an error by itself.
  always @(posedge clk) begin
    cpu_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transfer, expected none, actual pc %h acc %h",
                 $time, program_counter, accumulator);
      end else begin
        exp_res = pending_results.pop_front();
        check_field("program_counter", exp_res.pc, program_counter);
        check_field("accumulator", exp_res.acc, accumulator);
        check_field("status_flags", 16'(exp_res.flags), 16'(status_flags));
        check_field("executed_opcode", 16'(exp_res.op), 16'(executed_opcode));
        check_field("branch_taken", 16'(exp_res.taken), 16'(branch_taken));
      end
    end
  end

  // Receiver side. A rising hold request starts a long hold that this
  // process counts out; otherwise short random stall bursts when idling is on.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_seen  <= 1'b0;
    end else begin
      hold_seen <= hold_request;
      if (hold_request && !hold_seen) begin
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        stall_left <= $urandom_range(0, 5);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Walks every operation at least once, starting from cleared memory, and reaches
  // the corner cases: carry out of an add, a zero shift, a store and load
  // at the top address, a jump to the top address followed by an immediate
  // load whose operands wrap to the bottom, a jump through the same register
  // as its link, a jump that is never taken, and a write to a preset register.
  task automatic test_directed();
    idle_enable <= 1'b0;
    send_item(acs_pkg::CMD_STEP, 16'h0000, 8'h00);
    exec_instr({acs_pkg::OP_ADD, 5'd30}, 8'h00, 8'h00);
    exec_instr({acs_pkg::OP_SRL, 5'd0}, 8'h00, 8'h00);
    exec_instr({acs_pkg::OP_SETI, 5'd0}, 8'h00, 8'h80);
    exec_instr({acs_pkg::OP_SD, 5'd31}, 8'h00, 8'h00);
    exec_instr({acs_pkg::OP_LD, 5'd31}, 8'h00, 8'h00);
    exec_instr({acs_pkg::OP_JL, 5'd31}, {acs_pkg::COND_ALWAYS, 5'd1}, 8'h00);
    exec_instr({acs_pkg::OP_SETI, 5'd0}, 8'hff, 8'hff);
    exec_instr({acs_pkg::OP_JL, 5'd2}, {acs_pkg::COND_ALWAYS, 5'd2}, 8'h00);
    exec_instr({acs_pkg::OP_JL, 5'd0}, {acs_pkg::COND_NEVER, 5'd3}, 8'h00);
    exec_instr({acs_pkg::OP_MOVE, 5'd31}, 8'h00, 8'h00);
  endtask

  // Random programs with idling on both sides, broken up by calm stretches.
  task automatic test_random(input int count);
    for (int chunk = 0; chunk < count / 100; chunk++) begin
      idle_enable <= ($urandom_range(0, 3) != 0);
      random_mix(100);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering transfers, so the buffers fill and the input stalls.
  task automatic test_backpressure();
    idle_enable  <= 1'b0;
    hold_request <= 1'b1;
    for (int i = 0; i < 8; i++) random_instr();
    hold_request <= 1'b0;
  endtask

  // Closing stretch at full rate with no idling on either side.
  task automatic test_streaming(input int count);
    idle_enable <= 1'b0;
    random_mix(count);
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(1000);
    test_backpressure();
    test_streaming(150);

    // Let every predicted transfer arrive, then watch a little longer for
    // anything extra the block might still emit.
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
